// ===== rtl/ellipse_outline_rasterizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer assertion macros
// Shared concurrent assertion forms for the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_OUTLINE_RASTERIZER_UNIT_DEFINES_SVH
`define ELLIPSE_OUTLINE_RASTERIZER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define EORAST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define EORAST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/eorast_pkg.sv =====
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer package
// Widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package eorast_pkg;

   localparam int RADIUS_BITS = 12;
   localparam int PIXEL_BITS  = 17;
   localparam int STEP_BITS   = 13;
   localparam int SQ_BITS     = 2 * RADIUS_BITS;
   localparam int PROD_BITS   = SQ_BITS + STEP_BITS;
   localparam int ERR_BITS    = 48;

   localparam int DEF_MAX_RADIUS = 4095;
   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_COLOR_BITS = 32;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // multiplier operand selection
   localparam logic [1:0] MUL_AA   = 2'd0;
   localparam logic [1:0] MUL_BB   = 2'd1;
   localparam logic [1:0] MUL_B2A  = 2'd2;
   localparam logic [1:0] MUL_STEP = 2'd3;

   localparam logic [1:0] LAST_IDX = 2'd3;

   typedef struct packed {
      logic       load;
      logic [1:0] mul_sel;
      logic       cap_a2;
      logic       cap_b2;
      logic       cap_err;
      logic       step_upd;
      logic [1:0] emit_idx;
   } eorast_cmd_type;

   typedef struct packed {
      logic active;
   } eorast_stat_type;

endpackage

// ===== rtl/eorast_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer controller
// Sequences the start setup, the per-step update and the four-pixel output.
// ----------------------------------------------------------------------------
`include "ellipse_outline_rasterizer_unit_defines.svh"

module eorast_ctrl
   import eorast_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_func,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  eorast_stat_type stat,
   output eorast_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQ_A  = 3'd1;
   localparam logic [2:0] ST_SQ_B  = 3'd2;
   localparam logic [2:0] ST_SQ_C  = 3'd3;
   localparam logic [2:0] ST_ERR_M = 3'd4;
   localparam logic [2:0] ST_ERR_W = 3'd5;
   localparam logic [2:0] ST_UPD   = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.emit_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  cmd.load = 1'b1;
                  state_in = ST_SQ_A;
               end else if (stat.active) begin
                  // product for the step is taken from the current state
                  cmd.mul_sel = MUL_STEP;
                  state_in    = ST_UPD;
               end
            end
         end
         ST_SQ_A: begin
            cmd.mul_sel = MUL_AA;
            state_in    = ST_SQ_B;
         end
         ST_SQ_B: begin
            cmd.cap_a2  = 1'b1;
            cmd.mul_sel = MUL_BB;
            state_in    = ST_SQ_C;
         end
         ST_SQ_C: begin
            cmd.cap_b2 = 1'b1;
            state_in   = ST_ERR_M;
         end
         ST_ERR_M: begin
            cmd.mul_sel = MUL_B2A;
            state_in    = ST_ERR_W;
         end
         ST_ERR_W: begin
            cmd.cap_err = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_UPD: begin
            cmd.step_upd = 1'b1;
            idx_in       = 2'd0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `EORAST_ASSERT_NEXT(a_emit_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(idx_ff), "pixel index moved while output stalled")
   `EORAST_ASSERT(a_no_req_during_emit, clock, reset, rsp_valid |-> req_stall,
      "input taken while pixels pending")
   `EORAST_ASSERT_NEXT(a_step_to_upd, clock, reset,
      !req_stall && req_valid && req_func == FUNC_STEP && stat.active,
      state_ff == ST_UPD, "active step did not enter update")
   `EORAST_ASSERT_NEXT(a_last_frees_input, clock, reset,
      rsp_valid && !rsp_stall && idx_ff == LAST_IDX, !req_stall && !rsp_valid,
      "input not freed after last pixel")

endmodule

// ===== rtl/eorast_dpath.sv =====
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer datapath
// Walk state, shared multiplier, error update and mirrored pixel positions.
// ----------------------------------------------------------------------------
module eorast_dpath
   import eorast_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  eorast_cmd_type               cmd,
   output eorast_stat_type              stat,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   input  logic [COLOR_BITS-1:0]        req_pen_color,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_x,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_last_of_step,
   output logic                         rsp_done_res
);

   localparam int CMP_BITS = 17;

   logic                         active_ff;
   logic [RADIUS_BITS-1:0]       a_ff, b_ff;
   logic [SQ_BITS-1:0]           a2_ff, b2_ff;
   logic [STEP_BITS-1:0]         x_ff;
   logic signed [STEP_BITS-1:0]  y_ff;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic [PROD_BITS-1:0]         prod_ff, prod_in;
   logic signed [PIXEL_BITS-1:0] ox_ff, oy_ff;
   logic [COLOR_BITS-1:0]        color_ff;
   logic signed [PIXEL_BITS-1:0] xm_ff, xp_ff, ym_ff, yp_ff;
   logic                         done_ff, done_in;

   logic [RADIUS_BITS-1:0]       a_clamp, b_clamp;
   logic [SQ_BITS-1:0]           mul_l;
   logic [STEP_BITS-1:0]         mul_r;
   logic                         err_neg;
   logic [ERR_BITS-1:0]          twice_ext, sq_ext;
   logic signed [PIXEL_BITS-1:0] p_val, y_val;

   // saturate radii above the configured maximum
   assign a_clamp = ({{(CMP_BITS-RADIUS_BITS){1'b0}}, req_radius_x} > CMP_BITS'(MAX_RADIUS)) ?
                    RADIUS_BITS'(MAX_RADIUS) : req_radius_x;
   assign b_clamp = ({{(CMP_BITS-RADIUS_BITS){1'b0}}, req_radius_y} > CMP_BITS'(MAX_RADIUS)) ?
                    RADIUS_BITS'(MAX_RADIUS) : req_radius_y;

   assign err_neg = err_ff[ERR_BITS-1];

   always_comb begin
      mul_l = '0;
      mul_r = '0;
      case (cmd.mul_sel)
         MUL_AA: begin
            mul_l = SQ_BITS'(a_ff);
            mul_r = STEP_BITS'(a_ff);
         end
         MUL_BB: begin
            mul_l = SQ_BITS'(b_ff);
            mul_r = STEP_BITS'(b_ff);
         end
         MUL_B2A: begin
            mul_l = b2_ff;
            mul_r = STEP_BITS'(a_ff);
         end
         MUL_STEP: begin
            // y is never negative while the walk is active
            if (err_neg) begin
               mul_l = b2_ff;
               mul_r = x_ff;
            end else begin
               mul_l = a2_ff;
               mul_r = y_ff;
            end
         end
         default: begin
            mul_l = '0;
            mul_r = '0;
         end
      endcase
   end

   assign prod_in = PROD_BITS'(mul_l) * PROD_BITS'(mul_r);

   assign twice_ext = {{(ERR_BITS-PROD_BITS-1){1'b0}}, prod_ff, 1'b0};
   assign sq_ext    = {{(ERR_BITS-SQ_BITS){1'b0}}, (err_neg ? b2_ff : a2_ff)};
   assign err_in    = err_neg ? (err_ff + $signed(twice_ext) + $signed(sq_ext))
                              : (err_ff - $signed(twice_ext) + $signed(sq_ext));

   // p is the old x on an x advance, x-1 on a y step
   assign p_val   = err_neg ? $signed({{(PIXEL_BITS-STEP_BITS){1'b0}}, x_ff})
                            : $signed({{(PIXEL_BITS-STEP_BITS){1'b0}}, x_ff})
                              - $signed(PIXEL_BITS'(1));
   assign y_val   = PIXEL_BITS'(y_ff);
   assign done_in = !err_neg && (y_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (cmd.load) begin
         active_ff <= (a_clamp != '0) && (b_clamp != '0);
      end else if (cmd.step_upd && done_in) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         a_ff     <= a_clamp;
         b_ff     <= b_clamp;
         ox_ff    <= PIXEL_BITS'(req_center_x);
         oy_ff    <= PIXEL_BITS'(req_center_y);
         color_ff <= req_pen_color;
         x_ff     <= '0;
         y_ff     <= $signed({1'b0, b_clamp});
      end
      if (cmd.cap_a2) begin
         a2_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (cmd.cap_b2) begin
         b2_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (cmd.cap_err) begin
         err_ff <= $signed({ERR_BITS{1'b0}} - {{(ERR_BITS-PROD_BITS){1'b0}}, prod_ff});
      end
      if (cmd.step_upd) begin
         err_ff  <= err_in;
         xm_ff   <= ox_ff - p_val;
         xp_ff   <= ox_ff + p_val;
         ym_ff   <= oy_ff - y_val;
         yp_ff   <= oy_ff + y_val;
         done_ff <= done_in;
         if (err_neg) begin
            x_ff <= x_ff + 1'b1;
         end else begin
            y_ff <= y_ff - $signed(STEP_BITS'(1));
         end
      end
   end

   assign stat.active      = active_ff;
   assign rsp_pixel_x      = cmd.emit_idx[0] ? xp_ff : xm_ff;
   assign rsp_pixel_y      = cmd.emit_idx[1] ? yp_ff : ym_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_last_of_step = (cmd.emit_idx == LAST_IDX);
   assign rsp_done_res     = done_ff;

endmodule

// ===== rtl/ellipse_outline_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer
// Walks one quadrant of an ellipse outline and emits four mirrored pixels
// for every step item while an ellipse is running.
// ----------------------------------------------------------------------------
// A start item (func 0) loads centre, radii and colour, then passes a^2, b^2
// and b^2*a one after another through the single 24x13 multiplier; it
// produces no pixels. A step item (func 1) registers its product, then
// updates the error term and walk position, then emits its four pixels, one
// pixel per output cycle while rsp_stall is low. A step while no ellipse is
// running is taken and dropped.
// Pixels come out as (cx-p,cy-y), (cx+p,cy-y), (cx-p,cy+y), (cx+p,cy+y),
// unclipped; done_res marks all four pixels of the final step.
module ellipse_outline_rasterizer_unit
   import eorast_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   input  logic [COLOR_BITS-1:0]        req_pen_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_x,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_last_of_step,
   output logic                         rsp_done_res
);

   eorast_cmd_type  cmd;
   eorast_stat_type stat;

   eorast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   eorast_dpath #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_x     (req_radius_x),
      .req_radius_y     (req_radius_y),
      .req_pen_color    (req_pen_color),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

// ===== tb/tb_ellipse_outline_rasterizer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ellipse outline rasterizer testbench
// Sends start and step items to the rasterizer and compares every pixel it
// emits against a cycle-free predictor of the quadrant walk. Directed cases
// cover idle steps, zero radii, a full unit ellipse, coordinate extremes and
// restarts; random walks with and then without bursty idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_ellipse_outline_rasterizer_unit;
   import eorast_pkg::*;

   typedef struct {
      logic signed [PIXEL_BITS-1:0] pix_x;
      logic signed [PIXEL_BITS-1:0] pix_y;
      logic [DEF_COLOR_BITS-1:0]    color;
      logic                         last;
      logic                         done;
   } pixel_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_func = FUNC_STEP;
   logic signed [DEF_COORD_BITS-1:0] req_center_x = '0;
   logic signed [DEF_COORD_BITS-1:0] req_center_y = '0;
   logic [RADIUS_BITS-1:0]           req_radius_x = '0;
   logic [RADIUS_BITS-1:0]           req_radius_y = '0;
   logic [DEF_COLOR_BITS-1:0]        req_pen_color = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [PIXEL_BITS-1:0]     rsp_pixel_x;
   logic signed [PIXEL_BITS-1:0]     rsp_pixel_y;
   logic [DEF_COLOR_BITS-1:0]        rsp_pixel_color;
   logic                             rsp_last_of_step;
   logic                             rsp_done_res;

   // walk state of the predictor
   logic                      walk_active = 1'b0;
   longint                    walk_x = 0;
   longint                    walk_y = 0;
   longint                    walk_err = 0;
   longint                    org_x = 0;
   longint                    org_y = 0;
   longint                    a_sq = 0;
   longint                    b_sq = 0;
   logic [DEF_COLOR_BITS-1:0] walk_color = '0;

   pixel_type pending_pixels[$];
   int        productive_steps = 0;
   int        fail_count = 0;
   bit        req_idling = 1'b0;
   bit        rsp_idling = 1'b0;
   int        stall_left = 0;

   ellipse_outline_rasterizer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_x     (req_radius_x),
      .req_radius_y     (req_radius_y),
      .req_pen_color    (req_pen_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

   always #5 clock = ~clock;

   function automatic void push_pixel(input longint px, input longint py,
                                      input logic last, input logic done);
      pixel_type pix;
      pix.pix_x = px[PIXEL_BITS-1:0];
      pix.pix_y = py[PIXEL_BITS-1:0];
      pix.color = walk_color;
      pix.last  = last;
      pix.done  = done;
      pending_pixels.push_back(pix);
   endfunction

   function automatic void walk_ellipse(input logic func,
                                        input logic signed [DEF_COORD_BITS-1:0] cx,
                                        input logic signed [DEF_COORD_BITS-1:0] cy,
                                        input logic [RADIUS_BITS-1:0] rx,
                                        input logic [RADIUS_BITS-1:0] ry,
                                        input logic [DEF_COLOR_BITS-1:0] color);
      longint a;
      longint b;
      longint y;
      longint p;
      logic   done;
      if (func == FUNC_START) begin
         a = (rx > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : rx;
         b = (ry > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : ry;
         org_x       = cx;
         org_y       = cy;
         walk_color  = color;
         a_sq        = a * a;
         b_sq        = b * b;
         walk_x      = 0;
         walk_y      = b;
         walk_err    = -(b_sq * a);
         walk_active = (a != 0) && (b != 0);
         return;
      end
      if (!walk_active) return;
      productive_steps++;
      done = 1'b0;
      y    = walk_y;
      if (walk_err < 0) begin
         walk_err += 2 * walk_x * b_sq + b_sq;
         walk_x   += 1;
      end else begin
         walk_err += -2 * walk_y * a_sq + a_sq;
         if (walk_y == 0) begin
            done        = 1'b1;
            walk_active = 1'b0;
         end
         walk_y -= 1;
      end
      p = walk_x - 1;
      push_pixel(org_x - p, org_y - y, 1'b0, done);
      push_pixel(org_x + p, org_y - y, 1'b0, done);
      push_pixel(org_x - p, org_y + y, 1'b0, done);
      push_pixel(org_x + p, org_y + y, 1'b1, done);
   endfunction

   function automatic void check_field(input string label,
                                       input logic signed [63:0] want_v,
                                       input logic signed [63:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, label, want_v, got_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual x %0d y %0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", want.pix_x, rsp_pixel_x);
            check_field("pixel_y", want.pix_y, rsp_pixel_y);
            check_field("pixel_color", want.color, rsp_pixel_color);
            check_field("last_of_step", want.last, rsp_last_of_step);
            check_field("done_res", want.done, rsp_done_res);
         end
      end
   end

   // stall the pixel channel in random bursts while rsp_idling is set
   always @(posedge clock) begin
      if (reset || !rsp_idling) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // valid stays high between back-to-back items; drop it only for a gap
   task automatic send_item(input logic func,
                            input logic signed [DEF_COORD_BITS-1:0] cx,
                            input logic signed [DEF_COORD_BITS-1:0] cy,
                            input logic [RADIUS_BITS-1:0] rx,
                            input logic [RADIUS_BITS-1:0] ry,
                            input logic [DEF_COLOR_BITS-1:0] color);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_radius_x  <= rx;
      req_radius_y  <= ry;
      req_pen_color <= color;
      do @(posedge clock); while (req_stall);
      walk_ellipse(func, cx, cy, rx, ry, color);
   endtask

   task automatic send_step();
      send_item(FUNC_STEP, 16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
                $urandom);
   endtask

   // finish the running ellipse, then one ignored step
   task automatic walk_to_end();
      while (walk_active) send_step();
      send_step();
   endtask

   task automatic test_idle_step();
      send_step();
   endtask

   task automatic test_zero_radius();
      send_item(FUNC_START, 16'sd100, -16'sd100, 12'd0, 12'd7, 32'h1234_5678);
      send_step();
      send_item(FUNC_START, -16'sd5, 16'sd5, 12'd9, 12'd0, 32'h8765_4321);
      send_step();
   endtask

   task automatic test_unit_circle();
      send_item(FUNC_START, 16'sd0, 16'sd0, 12'd1, 12'd1, 32'hFFFF_FFFF);
      walk_to_end();
   endtask

   // extreme centres and radii; each start abandons the previous walk
   task automatic test_extremes();
      send_item(FUNC_START, 16'sh7FFF, -16'sh8000, 12'hFFF, 12'hFFF, 32'h0);
      repeat (3) send_step();
      send_item(FUNC_START, -16'sh8000, 16'sh7FFF, 12'd1, 12'hFFF, $urandom);
      repeat (3) send_step();
      send_item(FUNC_START, -16'sh8000, -16'sh8000, 12'hFFF, 12'd1, $urandom);
      repeat (3) send_step();
   endtask

   task automatic test_random_walks(input int step_target, input bit with_idling);
      int base;
      base = productive_steps;
      while (productive_steps - base < step_target) begin
         req_idling = with_idling && ($urandom_range(0, 3) != 0);
         rsp_idling = with_idling && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: begin
               send_item(1'($urandom), 16'($urandom), 16'($urandom), 12'($urandom),
                         12'($urandom), $urandom);
            end
            1: begin
               send_item(FUNC_START, 16'($urandom), 16'($urandom),
                         12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         $urandom);
               repeat ($urandom_range(1, 15)) send_step();
            end
            2: begin
               send_item(FUNC_START, 16'($urandom), 16'($urandom),
                         12'($urandom_range(0, 1) * 5), 12'($urandom_range(0, 1) * 3),
                         $urandom);
               repeat ($urandom_range(1, 3)) send_step();
            end
            default: begin
               send_item(FUNC_START, 16'($urandom), 16'($urandom),
                         12'($urandom_range(1, 10)), 12'($urandom_range(1, 10)),
                         $urandom);
               if ($urandom_range(0, 5) == 0) begin
                  repeat ($urandom_range(1, 8)) send_step();
               end else begin
                  walk_to_end();
               end
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_idle_step();
      test_zero_radius();
      test_unit_circle();
      test_extremes();
      test_random_walks(320, 1'b1);
      test_random_walks(80, 1'b0);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_ellipse_outline_rasterizer_unit: PASS");
      end else begin
         $display("tb_ellipse_outline_rasterizer_unit: FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_ellipse_outline_rasterizer_unit: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/eorast_pkg.sv
rtl/eorast_ctrl.sv
rtl/eorast_dpath.sv
rtl/ellipse_outline_rasterizer_unit.sv
tb/tb_ellipse_outline_rasterizer_unit.sv
